@@ sv/ipuc_pkg.sv @@
// Shared types and constants of the IPv4/UDP packet checker.
// No dependencies; every other file of the block but ipuc_if refers to this package.
`timescale 1ns / 1ps

package ipuc_pkg;

   localparam int UDP_HEADER_BYTES = 8;
   localparam int PROTOCOL_OFFSET  = 9;
   localparam int SOURCE_OFFSET    = 12;
   localparam int DEST_OFFSET      = 16;
   localparam int PORT_OFFSET      = 3;
   localparam int LENGTH_OFFSET    = 5;

   localparam logic [15:0] SUM_PASS = 16'hFFFF;

   localparam logic [1:0] CSR_SOURCE_ADDRESS      = 2'd0;
   localparam logic [1:0] CSR_DESTINATION_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_DESTINATION_PORT    = 2'd2;

   localparam logic [31:0] SOURCE_ADDRESS_RESET      = 32'h0A01010A;
   localparam logic [31:0] DESTINATION_ADDRESS_RESET = 32'h0A0101C8;
   localparam logic [15:0] DESTINATION_PORT_RESET    = 16'd42069;

   localparam logic [2:0] REASON_OK           = 3'd0;
   localparam logic [2:0] REASON_ADDRESS      = 3'd1;
   localparam logic [2:0] REASON_PORT         = 3'd2;
   localparam logic [2:0] REASON_IP_CHECKSUM  = 3'd3;
   localparam logic [2:0] REASON_UDP_CHECKSUM = 3'd4;
   localparam logic [2:0] REASON_BAD_LENGTH   = 3'd5;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] destination_port;
   } cfg_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       packet_end;
      logic       packet_ok;
      logic [2:0] fail_reason;
   } rsp_type;

endpackage

@@ sv/ipuc_if.sv @@
// Channel interfaces of the IPv4/UDP packet checker: stream in, results out, register writes.
// Each carries valid, ready and its payload; no dependencies.
`timescale 1ns / 1ps

interface ipuc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface ipuc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic       byte_valid;
   logic       packet_end;
   logic       packet_ok;
   logic [2:0] fail_reason;
   modport source (output valid, output payload_byte, output byte_valid, output packet_end,
                   output packet_ok, output fail_reason, input ready);
   modport sink (input valid, input payload_byte, input byte_valid, input packet_end,
                 input packet_ok, input fail_reason, output ready);
endinterface

interface ipuc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [31:0] write_data;
   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

@@ sv/ipv4_udp_packet_checker_top.sv @@
// Top level of the IPv4/UDP packet checker: registers, parser and result buffer.
// Depends on ipuc_pkg, ipuc_if, ipuc_csr_regs, ipuc_parser and ipuc_out_skid.
//
//   Channel   Direction  Beat contents
//   req_bus   in         stream_byte, one byte of the packet stream
//   rsp_bus   out        payload_byte, byte_valid, packet_end, packet_ok, fail_reason
//   csr_bus   in         reg_index, write_data (register write, always ready)
//
// One byte is accepted per cycle while req_bus.ready is high; each result is registered in the result buffer.
// The parser updates the per-packet state on each accepted byte.
// Reset is synchronous and restores the register defaults and the start of a header.
// A stalled result is held in the skid entry; req_bus.ready drops only while it is full.
`timescale 1ns / 1ps

module ipv4_udp_packet_checker_top #(
   parameter int IP_HEADER_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   ipuc_req_if.sink    req_bus,
   ipuc_rsp_if.source  rsp_bus,
   ipuc_csr_if.sink    csr_bus
);

   ipuc_pkg::cfg_type cfg;
   ipuc_pkg::rsp_type result;
   ipuc_pkg::rsp_type out_data;
   logic              result_push;
   logic              can_accept;
   logic              byte_accept;

   assign req_bus.ready = can_accept;
   assign byte_accept   = req_bus.valid && can_accept;

   ipuc_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   ipuc_parser #(
      .IP_HEADER_BYTES (IP_HEADER_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .byte_accept (byte_accept),
      .stream_byte (req_bus.stream_byte),
      .result_push (result_push),
      .result      (result)
   );

   ipuc_out_skid u_out_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (result_push),
      .push_data  (result),
      .can_accept (can_accept),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_data   (out_data)
   );

   assign rsp_bus.payload_byte = out_data.payload_byte;
   assign rsp_bus.byte_valid   = out_data.byte_valid;
   assign rsp_bus.packet_end   = out_data.packet_end;
   assign rsp_bus.packet_ok    = out_data.packet_ok;
   assign rsp_bus.fail_reason  = out_data.fail_reason;

endmodule

@@ sv/ipuc_csr_regs.sv @@
// Configuration registers: required addresses and destination port.
// Depends on ipuc_pkg and ipuc_csr_if.
`timescale 1ns / 1ps

module ipuc_csr_regs (
   input  logic               clock,
   input  logic               reset,
   ipuc_csr_if.sink           csr,
   output ipuc_pkg::cfg_type  cfg
);

   ipuc_pkg::cfg_type cfg_ff;

   assign csr.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_address      <= ipuc_pkg::SOURCE_ADDRESS_RESET;
         cfg_ff.destination_address <= ipuc_pkg::DESTINATION_ADDRESS_RESET;
         cfg_ff.destination_port    <= ipuc_pkg::DESTINATION_PORT_RESET;
      end else if (csr.valid) begin
         case (csr.reg_index)
            ipuc_pkg::CSR_SOURCE_ADDRESS: begin
               cfg_ff.source_address <= csr.write_data;
            end
            ipuc_pkg::CSR_DESTINATION_ADDRESS: begin
               cfg_ff.destination_address <= csr.write_data;
            end
            ipuc_pkg::CSR_DESTINATION_PORT: begin
               cfg_ff.destination_port <= csr.write_data[15:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

@@ sv/ipuc_parser.sv @@
// Per-byte packet parser: header checks, checksum sums and payload pass-through.
// Depends on ipuc_pkg; produces at most one result beat per accepted byte.
`timescale 1ns / 1ps

module ipuc_parser #(
   parameter int IP_HEADER_BYTES = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  ipuc_pkg::cfg_type  cfg,
   input  logic               byte_accept,
   input  logic [7:0]         stream_byte,
   output logic               result_push,
   output ipuc_pkg::rsp_type  result
);

   localparam int PosW = $clog2(IP_HEADER_BYTES + ipuc_pkg::UDP_HEADER_BYTES);
   localparam logic [PosW-1:0] POS_PROTOCOL = PosW'(ipuc_pkg::PROTOCOL_OFFSET);
   localparam logic [PosW-1:0] POS_SOURCE   = PosW'(ipuc_pkg::SOURCE_OFFSET);
   localparam logic [PosW-1:0] POS_DEST     = PosW'(ipuc_pkg::DEST_OFFSET);
   localparam logic [PosW-1:0] POS_IP_END   = PosW'(IP_HEADER_BYTES);
   localparam logic [PosW-1:0] POS_PORT     =
      PosW'(IP_HEADER_BYTES + ipuc_pkg::PORT_OFFSET);
   localparam logic [PosW-1:0] POS_LENGTH   =
      PosW'(IP_HEADER_BYTES + ipuc_pkg::LENGTH_OFFSET);
   localparam logic [PosW-1:0] POS_LAST     =
      PosW'(IP_HEADER_BYTES + ipuc_pkg::UDP_HEADER_BYTES - 1);
   localparam logic [15:0] UDP_HDR = 16'(ipuc_pkg::UDP_HEADER_BYTES);

   logic [PosW-1:0] pos_ff, pos_in;
   logic            in_payload_ff, in_payload_in;
   logic [15:0]     remaining_ff, remaining_in;
   logic [15:0]     ip_sum_ff, ip_sum_in;
   logic [15:0]     udp_sum_ff, udp_sum_in;
   logic [7:0]      pending_ff, pending_in;
   logic            odd_ff, odd_in;
   logic            addr_bad_ff, addr_bad_in;
   logic            port_bad_ff, port_bad_in;
   logic            len_bad_ff, len_bad_in;

   logic [15:0] word;
   logic [15:0] udp_a, udp_b, udp_c;
   logic [15:0] remaining_dec;
   logic [7:0]  want_byte;
   logic        odd_pos;
   logic        close;
   logic [2:0]  reason;

   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] w);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, w};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   assign word          = {pending_ff, stream_byte};
   assign odd_pos       = pos_ff[0];
   assign remaining_dec = remaining_ff - 16'd1;

   always_comb begin
      case (pos_ff[1:0])
         2'd0: want_byte = (pos_ff < POS_DEST) ? cfg.source_address[31:24]
                                               : cfg.destination_address[31:24];
         2'd1: want_byte = (pos_ff < POS_DEST) ? cfg.source_address[23:16]
                                               : cfg.destination_address[23:16];
         2'd2: want_byte = (pos_ff < POS_DEST) ? cfg.source_address[15:8]
                                               : cfg.destination_address[15:8];
         default: want_byte = (pos_ff < POS_DEST) ? cfg.source_address[7:0]
                                                  : cfg.destination_address[7:0];
      endcase
   end

   always_comb begin
      pos_in        = pos_ff;
      in_payload_in = in_payload_ff;
      remaining_in  = remaining_ff;
      ip_sum_in     = ip_sum_ff;
      udp_sum_in    = udp_sum_ff;
      pending_in    = pending_ff;
      odd_in        = odd_ff;
      addr_bad_in   = addr_bad_ff;
      port_bad_in   = port_bad_ff;
      len_bad_in    = len_bad_ff;
      udp_a         = udp_sum_ff;
      udp_b         = udp_sum_ff;
      udp_c         = udp_sum_ff;
      close         = 1'b0;

      if (in_payload_ff) begin
         if (!odd_ff) begin
            pending_in = stream_byte;
            odd_in     = 1'b1;
            udp_a      = udp_sum_ff;
         end else begin
            udp_a  = ones_add(udp_sum_ff, word);
            odd_in = 1'b0;
         end
         remaining_in = remaining_dec;
         close        = (remaining_dec == 16'd0);
         udp_b        = (close && !odd_ff) ? ones_add(udp_a, {stream_byte, 8'd0}) : udp_a;
         udp_sum_in   = udp_b;
      end else begin
         if (!odd_pos) begin
            pending_in = stream_byte;
         end
         udp_a = (pos_ff == POS_PROTOCOL) ? ones_add(udp_sum_ff, {8'd0, stream_byte})
                                          : udp_sum_ff;
         udp_b = (odd_pos && pos_ff >= POS_SOURCE) ? ones_add(udp_a, word) : udp_a;
         udp_c = (odd_pos && pos_ff == POS_LENGTH) ? ones_add(udp_b, word) : udp_b;
         udp_sum_in = udp_c;
         if (pos_ff >= POS_SOURCE && pos_ff < POS_IP_END && want_byte != stream_byte) begin
            addr_bad_in = 1'b1;
         end
         if (odd_pos && pos_ff < POS_IP_END) begin
            ip_sum_in = ones_add(ip_sum_ff, word);
         end
         if (odd_pos && pos_ff == POS_PORT && word != cfg.destination_port) begin
            port_bad_in = 1'b1;
         end
         if (odd_pos && pos_ff == POS_LENGTH) begin
            if (word < UDP_HDR) begin
               len_bad_in   = 1'b1;
               remaining_in = 16'd0;
            end else begin
               remaining_in = word - UDP_HDR;
            end
         end
         if (pos_ff == POS_LAST) begin
            close         = len_bad_in || (remaining_in == 16'd0);
            in_payload_in = 1'b1;
            odd_in        = 1'b0;
            pos_in        = '0;
         end else begin
            pos_in = pos_ff + PosW'(1);
         end
      end

      if (len_bad_in) begin
         reason = ipuc_pkg::REASON_BAD_LENGTH;
      end else if (addr_bad_in) begin
         reason = ipuc_pkg::REASON_ADDRESS;
      end else if (port_bad_in) begin
         reason = ipuc_pkg::REASON_PORT;
      end else if (ip_sum_in != ipuc_pkg::SUM_PASS) begin
         reason = ipuc_pkg::REASON_IP_CHECKSUM;
      end else if (udp_sum_in != ipuc_pkg::SUM_PASS) begin
         reason = ipuc_pkg::REASON_UDP_CHECKSUM;
      end else begin
         reason = ipuc_pkg::REASON_OK;
      end

      result.payload_byte = in_payload_ff ? stream_byte : 8'd0;
      result.byte_valid   = in_payload_ff;
      result.packet_end   = close;
      result.packet_ok    = close && (reason == ipuc_pkg::REASON_OK);
      result.fail_reason  = close ? reason : ipuc_pkg::REASON_OK;
      result_push         = byte_accept && (in_payload_ff || close);
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_accept && close)) begin
         pos_ff        <= '0;
         in_payload_ff <= 1'b0;
         remaining_ff  <= '0;
         ip_sum_ff     <= '0;
         udp_sum_ff    <= '0;
         pending_ff    <= '0;
         odd_ff        <= 1'b0;
         addr_bad_ff   <= 1'b0;
         port_bad_ff   <= 1'b0;
         len_bad_ff    <= 1'b0;
      end else if (byte_accept) begin
         pos_ff        <= pos_in;
         in_payload_ff <= in_payload_in;
         remaining_ff  <= remaining_in;
         ip_sum_ff     <= ip_sum_in;
         udp_sum_ff    <= udp_sum_in;
         pending_ff    <= pending_in;
         odd_ff        <= odd_in;
         addr_bad_ff   <= addr_bad_in;
         port_bad_ff   <= port_bad_in;
         len_bad_ff    <= len_bad_in;
      end
   end

endmodule

@@ sv/ipuc_out_skid.sv @@
// Result register with a skid entry, so the input side sees a registered ready.
// Depends on ipuc_pkg for the result beat type.
`timescale 1ns / 1ps

module ipuc_out_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ipuc_pkg::rsp_type  push_data,
   output logic               can_accept,
   output logic               out_valid,
   input  logic               out_ready,
   output ipuc_pkg::rsp_type  out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   ipuc_pkg::rsp_type main_ff, main_in;
   ipuc_pkg::rsp_type skid_ff, skid_in;

   assign can_accept = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_in       = main_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || out_ready) begin
         main_valid_in = skid_valid_ff || push;
         main_in       = skid_valid_ff ? skid_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

@@ tb/ipuc_stream_checker.sv @@
// Checker for the IPv4/UDP packet checker: watches the stream, result and register channels.
// Predicts every result beat from the accepted stream bytes and compares it in order.
// Depends on ipuc_pkg and ipuc_if.
`timescale 1ns / 1ps

module ipuc_stream_checker import ipuc_pkg::*; #(
   parameter int IP_HEADER_BYTES = 20
) (
   input  logic clock,
   input  logic reset,
   ipuc_req_if  req_bus,
   ipuc_rsp_if  rsp_bus,
   ipuc_csr_if  csr_bus,
   output int   mismatch_count,
   output int   awaited_results
);

   cfg_type     filters;
   rsp_type     expected_beats[$];
   int          faults;
   int          beats_checked;

   logic [4:0]  hdr_pos;
   logic        in_body;
   logic [15:0] body_left;
   logic [15:0] ip_acc;
   logic [15:0] udp_acc;
   logic [7:0]  high_byte;
   logic        odd_phase;
   logic        addr_bad;
   logic        port_bad;
   logic        len_bad;

   function automatic logic [15:0] ones_fold_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] total;
      total = {1'b0, acc} + {1'b0, word};
      return total[15:0] + {15'd0, total[16]};
   endfunction

   function automatic void start_packet();
      hdr_pos   = '0;
      in_body   = 1'b0;
      body_left = '0;
      ip_acc    = '0;
      udp_acc   = '0;
      high_byte = '0;
      odd_phase = 1'b0;
      addr_bad  = 1'b0;
      port_bad  = 1'b0;
      len_bad   = 1'b0;
   endfunction

   function automatic rsp_type close_verdict(input logic [7:0] last_byte, input logic carries_byte);
      rsp_type    beat;
      logic [2:0] why;
      if (len_bad) begin
         why = REASON_BAD_LENGTH;
      end else if (addr_bad) begin
         why = REASON_ADDRESS;
      end else if (port_bad) begin
         why = REASON_PORT;
      end else if (ip_acc != SUM_PASS) begin
         why = REASON_IP_CHECKSUM;
      end else if (udp_acc != SUM_PASS) begin
         why = REASON_UDP_CHECKSUM;
      end else begin
         why = REASON_OK;
      end
      beat.payload_byte = last_byte;
      beat.byte_valid   = carries_byte;
      beat.packet_end   = 1'b1;
      beat.packet_ok    = (why == REASON_OK);
      beat.fail_reason  = why;
      start_packet();
      return beat;
   endfunction

   // Returns 1 when the byte produces a result beat.
   function automatic bit parse_stream_byte(input logic [7:0] b, output rsp_type beat);
      logic [15:0] word;
      int          pos;
      beat = '0;
      if (in_body) begin
         if (!odd_phase) begin
            high_byte = b;
            odd_phase = 1'b1;
         end else begin
            udp_acc   = ones_fold_add(udp_acc, {high_byte, b});
            odd_phase = 1'b0;
         end
         body_left = body_left - 16'd1;
         if (body_left == 16'd0) begin
            if (odd_phase) begin
               udp_acc = ones_fold_add(udp_acc, {high_byte, 8'h00});
            end
            beat = close_verdict(b, 1'b1);
         end else begin
            beat.payload_byte = b;
            beat.byte_valid   = 1'b1;
         end
         return 1'b1;
      end

      pos  = int'(hdr_pos);
      word = {high_byte, b};
      if (!hdr_pos[0]) begin
         high_byte = b;
      end
      if (pos == PROTOCOL_OFFSET) begin
         udp_acc = ones_fold_add(udp_acc, {8'h00, b});
      end
      if (pos >= SOURCE_OFFSET && pos < SOURCE_OFFSET + 4 &&
          b != filters.source_address[8 * (SOURCE_OFFSET + 3 - pos) +: 8]) begin
         addr_bad = 1'b1;
      end
      if (pos >= DEST_OFFSET && pos < DEST_OFFSET + 4 &&
          b != filters.destination_address[8 * (DEST_OFFSET + 3 - pos) +: 8]) begin
         addr_bad = 1'b1;
      end
      if (hdr_pos[0]) begin
         if (pos < IP_HEADER_BYTES) begin
            ip_acc = ones_fold_add(ip_acc, word);
         end
         if (pos >= SOURCE_OFFSET) begin
            udp_acc = ones_fold_add(udp_acc, word);
         end
         if (pos == IP_HEADER_BYTES + PORT_OFFSET && word != filters.destination_port) begin
            port_bad = 1'b1;
         end
         if (pos == IP_HEADER_BYTES + LENGTH_OFFSET) begin
            udp_acc = ones_fold_add(udp_acc, word);
            if (word < UDP_HEADER_BYTES) begin
               len_bad   = 1'b1;
               body_left = '0;
            end else begin
               body_left = word - 16'(UDP_HEADER_BYTES);
            end
         end
      end

      if (pos == IP_HEADER_BYTES + UDP_HEADER_BYTES - 1) begin
         if (len_bad || body_left == 16'd0) begin
            beat = close_verdict(8'h00, 1'b0);
            return 1'b1;
         end
         in_body   = 1'b1;
         odd_phase = 1'b0;
         hdr_pos   = '0;
         return 1'b0;
      end
      hdr_pos = hdr_pos + 5'd1;
      return 1'b0;
   endfunction

   function automatic string describe_beat(input rsp_type r);
      return $sformatf("byte %02h valid %0b end %0b ok %0b reason %0d",
                       r.payload_byte, r.byte_valid, r.packet_end, r.packet_ok, r.fail_reason);
   endfunction

   task automatic report_fault(input string msg);
      faults++;
      if (faults <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin : beat_monitor
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         filters.source_address      = SOURCE_ADDRESS_RESET;
         filters.destination_address = DESTINATION_ADDRESS_RESET;
         filters.destination_port    = DESTINATION_PORT_RESET;
         expected_beats.delete();
         faults        = 0;
         beats_checked = 0;
         start_packet();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.payload_byte = rsp_bus.payload_byte;
            seen.byte_valid   = rsp_bus.byte_valid;
            seen.packet_end   = rsp_bus.packet_end;
            seen.packet_ok    = rsp_bus.packet_ok;
            seen.fail_reason  = rsp_bus.fail_reason;
            if (expected_beats.size() == 0) begin
               report_fault($sformatf("unexpected beat: %s", describe_beat(seen)));
            end else begin
               want = expected_beats.pop_front();
               if (seen !== want) begin
                  report_fault($sformatf("beat %0d mismatch: expected %s, got %s",
                                         beats_checked, describe_beat(want), describe_beat(seen)));
               end
            end
            beats_checked++;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               CSR_SOURCE_ADDRESS: begin
                  filters.source_address = csr_bus.write_data;
               end
               CSR_DESTINATION_ADDRESS: begin
                  filters.destination_address = csr_bus.write_data;
               end
               CSR_DESTINATION_PORT: begin
                  filters.destination_port = csr_bus.write_data[15:0];
               end
               default: begin
               end
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            if (parse_stream_byte(req_bus.stream_byte, want)) begin
               expected_beats.push_back(want);
            end
         end
      end
      mismatch_count  <= faults;
      awaited_results <= expected_beats.size();
   end

endmodule

@@ tb/testbench.sv @@
// Top of the IPv4/UDP packet checker testbench: clock, reset, packet stimulus and verdict.
// Drives directed and random datagrams under several filter settings with random idling.
// Depends on ipuc_pkg, ipuc_if, ipv4_udp_packet_checker_top and ipuc_stream_checker.
`timescale 1ns / 1ps

module testbench import ipuc_pkg::*;;

   localparam int          IP_HEADER_BYTES = 20;
   localparam int          CYCLE_LIMIT     = 1000000;
   localparam int          DRAIN_LIMIT     = 5000;
   localparam int          SETTLE_CYCLES   = 4;
   localparam int          PHASE_BYTES     = 200;
   localparam logic [7:0]  UDP_PROTOCOL    = 8'd17;
   localparam logic [1:0]  CSR_SPARE_INDEX = 2'd3;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   awaited_results;
   int   run_cycles = 0;
   int   stream_bytes = 0;
   bit   calm = 1'b0;
   int   sender_gap_odds = 3;
   int   sink_stall_odds = 4;

   logic [31:0] cfg_src  = SOURCE_ADDRESS_RESET;
   logic [31:0] cfg_dst  = DESTINATION_ADDRESS_RESET;
   logic [15:0] cfg_port = DESTINATION_PORT_RESET;

   ipuc_req_if req_bus ();
   ipuc_rsp_if rsp_bus ();
   ipuc_csr_if csr_bus ();

   ipv4_udp_packet_checker_top #(
      .IP_HEADER_BYTES(IP_HEADER_BYTES)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   ipuc_stream_checker #(
      .IP_HEADER_BYTES(IP_HEADER_BYTES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .awaited_results(awaited_results)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int pick_idle_odds();
      case ($urandom_range(0, 2))
         0: begin
            return 0;
         end
         1: begin
            return 3;
         end
         default: begin
            return 12;
         end
      endcase
   endfunction

   function automatic logic [7:0] stream_fill();
      case ($urandom_range(0, 7))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic logic [15:0] fold_carries(input int unsigned acc);
      while (acc > 32'h0000FFFF) begin
         acc = (acc & 32'h0000FFFF) + (acc >> 16);
      end
      return acc[15:0];
   endfunction

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
            stall_left = $urandom_range(1, 13) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         if ($urandom_range(0, 63) == 0) begin
            sink_stall_odds = pick_idle_odds();
         end
      end
   end

   task automatic send_stream_byte(input logic [7:0] b);
      if (!calm && sender_gap_odds != 0 && $urandom_range(1, sender_gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.stream_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      stream_bytes++;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaited_results != 0);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= idx;
      csr_bus.write_data <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic load_filters(input logic [31:0] src, input logic [31:0] dst,
                               input logic [31:0] port_data, input bit poke_spare);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_SOURCE_ADDRESS, src);
      write_register(CSR_DESTINATION_ADDRESS, dst);
      write_register(CSR_DESTINATION_PORT, port_data);
      if (poke_spare) begin
         write_register(CSR_SPARE_INDEX, $urandom());
      end
      csr_bus.valid <= 1'b0;
      cfg_src  = src;
      cfg_dst  = dst;
      cfg_port = port_data[15:0];
   endtask

   task automatic send_datagram(input logic [31:0] src, input logic [31:0] dst,
                                input logic [15:0] dport, input logic [15:0] ulen,
                                input int body_len, input bit spoil_ip, input bit spoil_udp);
      logic [7:0]  pkt[$];
      int unsigned acc;
      logic [15:0] cks;
      int          i;
      pkt = {};
      for (i = 0; i < 12; i++) begin
         pkt.push_back(stream_fill());
      end
      pkt[PROTOCOL_OFFSET] = ($urandom_range(0, 3) != 0) ? UDP_PROTOCOL : stream_fill();
      pkt[10] = 8'h00;
      pkt[11] = 8'h00;
      for (i = 3; i >= 0; i--) begin
         pkt.push_back(src[8 * i +: 8]);
      end
      for (i = 3; i >= 0; i--) begin
         pkt.push_back(dst[8 * i +: 8]);
      end
      acc = 0;
      for (i = 0; i < IP_HEADER_BYTES; i += 2) begin
         acc += {pkt[i], pkt[i + 1]};
      end
      cks = ~fold_carries(acc);
      if (spoil_ip) begin
         cks ^= 16'($urandom_range(1, 65535));
      end
      pkt[10] = cks[15:8];
      pkt[11] = cks[7:0];

      pkt.push_back(stream_fill());
      pkt.push_back(stream_fill());
      pkt.push_back(dport[15:8]);
      pkt.push_back(dport[7:0]);
      pkt.push_back(ulen[15:8]);
      pkt.push_back(ulen[7:0]);
      pkt.push_back(8'h00);
      pkt.push_back(8'h00);
      for (i = 0; i < body_len; i++) begin
         pkt.push_back(stream_fill());
      end
      acc = pkt[PROTOCOL_OFFSET] + src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + ulen;
      for (i = IP_HEADER_BYTES; i < pkt.size(); i += 2) begin
         acc += {pkt[i], (i + 1 < pkt.size()) ? pkt[i + 1] : 8'h00};
      end
      cks = ~fold_carries(acc);
      if (spoil_udp) begin
         cks ^= 16'($urandom_range(1, 65535));
      end
      pkt[IP_HEADER_BYTES + UDP_HEADER_BYTES - 2] = cks[15:8];
      pkt[IP_HEADER_BYTES + UDP_HEADER_BYTES - 1] = cks[7:0];
      foreach (pkt[k]) begin
         send_stream_byte(pkt[k]);
      end
   endtask

   task automatic send_random_datagram();
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] dport;
      logic [15:0] ulen;
      int          body_len;
      bit          spoil_ip;
      bit          spoil_udp;
      src       = cfg_src;
      dst       = cfg_dst;
      dport     = cfg_port;
      body_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
      ulen      = 16'(body_len + UDP_HEADER_BYTES);
      spoil_ip  = ($urandom_range(0, 11) == 0);
      spoil_udp = ($urandom_range(0, 11) == 0);
      if ($urandom_range(0, 11) == 0) begin
         src ^= 32'h1 << $urandom_range(0, 31);
      end
      if ($urandom_range(0, 11) == 0) begin
         dst ^= 32'h1 << $urandom_range(0, 31);
      end
      if ($urandom_range(0, 11) == 0) begin
         dport ^= 16'h1 << $urandom_range(0, 15);
      end
      case ($urandom_range(0, 19))
         0, 1: begin
            src       = $urandom();
            dst       = $urandom();
            dport     = 16'($urandom());
            ulen      = 16'($urandom_range(0, 48));
            body_len  = (ulen < UDP_HEADER_BYTES) ? 0 : int'(ulen) - UDP_HEADER_BYTES;
            spoil_ip  = 1'($urandom_range(0, 1));
            spoil_udp = 1'($urandom_range(0, 1));
         end
         2: begin
            ulen     = 16'($urandom_range(0, UDP_HEADER_BYTES - 1));
            body_len = 0;
         end
         default: begin
         end
      endcase
      if ($urandom_range(0, 5) == 0) begin
         sender_gap_odds = pick_idle_odds();
      end
      send_datagram(src, dst, dport, ulen, body_len, spoil_ip, spoil_udp);
      if ($urandom_range(0, 39) == 0) begin
         wait_for_results();
      end
   endtask

   initial begin : stimulus
      int goal;
      int i;
      reset               = 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.stream_byte <= 8'h00;
      csr_bus.valid       <= 1'b0;
      csr_bus.reg_index   <= CSR_SOURCE_ADDRESS;
      csr_bus.write_data  <= 32'h0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd12, 4, 1'b0, 1'b0);
      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd11, 3, 1'b0, 1'b0);
      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd9, 1, 1'b0, 1'b0);
      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd8, 0, 1'b0, 1'b0);
      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd0, 0, 1'b0, 1'b0);
      send_datagram(cfg_src ^ 32'h100, cfg_dst, cfg_port, 16'd7, 0, 1'b1, 1'b1);
      send_datagram(cfg_src ^ 32'h80000000, cfg_dst, cfg_port, 16'd10, 2, 1'b0, 1'b0);
      send_datagram(cfg_src, cfg_dst ^ 32'h1, cfg_port, 16'd10, 2, 1'b0, 1'b0);
      send_datagram(cfg_src, cfg_dst, cfg_port ^ 16'h8000, 16'd13, 5, 1'b0, 1'b0);
      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd14, 6, 1'b1, 1'b0);
      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd15, 7, 1'b0, 1'b1);
      send_datagram(cfg_src ^ 32'h10000, cfg_dst, cfg_port ^ 16'h1, 16'd9, 1, 1'b1, 1'b1);
      send_datagram(cfg_src, cfg_dst, cfg_port ^ 16'h10, 16'd10, 2, 1'b1, 1'b1);
      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd11, 3, 1'b1, 1'b1);
      send_datagram(cfg_src, cfg_dst, cfg_port, 16'd8, 0, 1'b0, 1'b1);
      wait_for_results();

      for (i = 0; i < 4; i++) begin
         case (i)
            0: begin
               load_filters(32'h0, 32'hFFFFFFFF, 32'h0, 1'b0);
            end
            1: begin
               load_filters(32'hFFFFFFFF, 32'h0, 32'hABCDFFFF, 1'b1);
            end
            default: begin
               load_filters($urandom(), $urandom(), $urandom(), 1'b0);
            end
         endcase
         calm = (i == 3);
         goal = stream_bytes + PHASE_BYTES;
         while (stream_bytes < goal) begin
            send_random_datagram();
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      for (i = 0; i < DRAIN_LIMIT && awaited_results != 0; i++) begin
         @(posedge clock);
      end
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (awaited_results != 0) begin
         $display("%0d expected beats never arrived", awaited_results);
      end
      if (mismatch_count == 0 && awaited_results == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
